// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the clock setter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== design/phcs_pkg.sv =====
// ----------------------------------------------------------------------------
// phcs_pkg
// Codes, widths and constants for the press/hold clock setter.
// ----------------------------------------------------------------------------
`default_nettype none

package phcs_pkg;

	localparam int unsigned CountW  = 16;
	localparam int unsigned HourW   = 5;
	localparam int unsigned MinuteW = 6;

	localparam logic [CountW-1:0] HoldThresholdReset = 16'd4000;
	localparam logic [CountW-1:0] CountMax           = 16'hFFFF;

	localparam logic [6:0] MinutesPerHour = 7'd60;
	localparam logic [5:0] HoursPerDay    = 6'd24;
	localparam logic [6:0] TenMinutes     = 7'd10;

	// input op codes
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_EDGE = 1'b1;

	// event kinds
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_PRESS = 2'd1;
	localparam logic [1:0] EV_HOLD  = 2'd2;

	// adjust selector codes
	localparam logic [1:0] SEL_MODE   = 2'd0;
	localparam logic [1:0] SEL_MINUTE = 2'd1;
	localparam logic [1:0] SEL_TEN    = 2'd2;
	localparam logic [1:0] SEL_HOUR   = 2'd3;

	typedef struct packed {
		logic [1:0]         event_kind;
		logic               set_time;
		logic [HourW-1:0]   new_hour;
		logic [MinuteW-1:0] new_minute;
		logic               display_mode;
		logic [1:0]         adjust_select;
	} result_t;

endpackage

`default_nettype wire

// ===== design/press_hold_clock_setter_core.sv =====
// ----------------------------------------------------------------------------
// press_hold_clock_setter_core
// Button press/hold classifier that adjusts a 24-hour clock time.
// ----------------------------------------------------------------------------
// Each input word is a timer tick (op 0) or a mode button level change
// (op 1) together with the clock's current hour and minute. The first edge
// arms a saturating 16-bit tick counter; the next edge disarms it and
// classifies the action: a count above hold_threshold is a hold and steps the
// adjust selector, anything else is a short press that toggles the display
// mode (selector 0) or adds one minute, ten minutes or one hour (selectors
// 1, 2, 3) with minute carry and 24-hour wrap. Every input word yields
// exactly one output word. The block takes one word per clock while the output
// does not stall, set by the single pass of logic between the input register
// and the result register. An input word waits in the input register and its
// result word in the result register, which drives the output. While the
// output stalls, the input register takes one more word and then in_stall
// rises. hold_threshold resets to 4000 and is written through cfg_we/cfg_data.
// ----------------------------------------------------------------------------
`default_nettype none

module press_hold_clock_setter_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               cfg_we,
	input  wire logic [phcs_pkg::CountW-1:0]        cfg_data,
	// input channel
	input  wire logic                               in_valid,
	output      logic                               in_stall,
	input  wire logic                               op,
	input  wire logic [phcs_pkg::HourW-1:0]         clock_hour,
	input  wire logic [phcs_pkg::MinuteW-1:0]       clock_minute,
	// output channel
	output      logic                               out_valid,
	input  wire logic                               out_stall,
	output      logic [1:0]                         event_kind,
	output      logic                               set_time,
	output      logic [phcs_pkg::HourW-1:0]         new_hour,
	output      logic [phcs_pkg::MinuteW-1:0]       new_minute,
	output      logic                               display_mode_out,
	output      logic [1:0]                         adjust_select_out
);

`include "assert_macros.svh"

	// ---------------- configuration ----------------
	logic [phcs_pkg::CountW-1:0] hold_threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_threshold_q <= phcs_pkg::HoldThresholdReset;
		end else if (cfg_we) begin
			hold_threshold_q <= cfg_data;
		end
	end

	// ---------------- handshake ----------------
	logic                          valid_s1;
	logic                          op_s1;
	logic [phcs_pkg::HourW-1:0]    hour_s1;
	logic [phcs_pkg::MinuteW-1:0]  minute_s1;
	logic                          valid_s2;
	phcs_pkg::result_t             res_s2;

	logic s2_load;   // result register free or being drained
	logic in_fire;
	logic adv;       // stage 1 word processed into result register

	assign s2_load  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !s2_load;
	assign in_fire  = in_valid && !in_stall;
	assign adv      = valid_s1 && s2_load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || s2_load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= op;
			hour_s1   <= clock_hour;
			minute_s1 <= clock_minute;
		end
	end

	// ---------------- classifier state ----------------
	logic                        armed_q;
	logic [phcs_pkg::CountW-1:0] hold_count_q;
	logic [1:0]                  adjust_select_q;
	logic                        display_mode_q;

	logic                        armed_d;
	logic [phcs_pkg::CountW-1:0] hold_count_d;
	logic [1:0]                  adjust_select_d;
	logic                        display_mode_d;
	logic                        is_hold;
	phcs_pkg::result_t           res_d;

	// time adjust datapath
	logic [6:0] minute_add;
	logic       hour_add;
	logic [6:0] minute_sum;
	logic       carry;
	logic [6:0] minute_fix;
	logic [5:0] hour_sum;
	logic [5:0] hour_fix;

	assign is_hold = hold_count_q > hold_threshold_q;

	always_comb begin
		minute_add = 7'd0;
		hour_add   = 1'b0;
		case (adjust_select_q)
			phcs_pkg::SEL_HOUR:   hour_add   = 1'b1;
			phcs_pkg::SEL_TEN:    minute_add = phcs_pkg::TenMinutes;
			phcs_pkg::SEL_MINUTE: minute_add = 7'd1;
			default:              minute_add = 7'd0;
		endcase
		minute_sum = {1'b0, minute_s1} + minute_add;
		carry      = minute_sum >= phcs_pkg::MinutesPerHour;
		minute_fix = carry ? (minute_sum - phcs_pkg::MinutesPerHour) : minute_sum;
		// hour is at most 31 + 2, so one subtract covers the wrap
		hour_sum   = {1'b0, hour_s1} + {5'd0, hour_add} + {5'd0, carry};
		hour_fix   = (hour_sum >= phcs_pkg::HoursPerDay) ?
			(hour_sum - phcs_pkg::HoursPerDay) : hour_sum;
	end

	always_comb begin
		armed_d         = armed_q;
		hold_count_d    = hold_count_q;
		adjust_select_d = adjust_select_q;
		display_mode_d  = display_mode_q;
		res_d.event_kind = phcs_pkg::EV_NONE;
		res_d.set_time   = 1'b0;
		res_d.new_hour   = '0;
		res_d.new_minute = '0;

		if (op_s1 == phcs_pkg::OP_TICK) begin
			if (armed_q && hold_count_q != phcs_pkg::CountMax) begin
				hold_count_d = hold_count_q + 16'd1;
			end
		end else if (!armed_q) begin
			armed_d      = 1'b1;
			hold_count_d = '0;
		end else begin
			armed_d      = 1'b0;
			hold_count_d = '0;
			if (is_hold) begin
				res_d.event_kind = phcs_pkg::EV_HOLD;
				adjust_select_d  = adjust_select_q + 2'd1;
			end else begin
				res_d.event_kind = phcs_pkg::EV_PRESS;
				if (adjust_select_q == phcs_pkg::SEL_MODE) begin
					display_mode_d = !display_mode_q;
				end else begin
					res_d.set_time   = 1'b1;
					res_d.new_hour   = hour_fix[phcs_pkg::HourW-1:0];
					res_d.new_minute = minute_fix[phcs_pkg::MinuteW-1:0];
				end
			end
		end
		res_d.display_mode  = display_mode_d;
		res_d.adjust_select = adjust_select_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q         <= 1'b0;
			hold_count_q    <= '0;
			adjust_select_q <= phcs_pkg::SEL_MODE;
			display_mode_q  <= 1'b0;
		end else if (adv) begin
			armed_q         <= armed_d;
			hold_count_q    <= hold_count_d;
			adjust_select_q <= adjust_select_d;
			display_mode_q  <= display_mode_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid         = valid_s2;
	assign event_kind        = res_s2.event_kind;
	assign set_time          = res_s2.set_time;
	assign new_hour          = res_s2.new_hour;
	assign new_minute        = res_s2.new_minute;
	assign display_mode_out  = res_s2.display_mode;
	assign adjust_select_out = res_s2.adjust_select;

	// ---------------- assertions ----------------
	`ASSERT_NEVER(a_count_unarmed, clk, arst_n, (!armed_q && hold_count_q != '0), "count while not armed")
	`ASSERT_CLK(a_set_on_press, clk, arst_n, (valid_s2 && res_s2.set_time |-> res_s2.event_kind == phcs_pkg::EV_PRESS), "set_time without press")
	`ASSERT_CLK(a_time_range, clk, arst_n, (valid_s2 |-> res_s2.new_hour < 5'd24 && res_s2.new_minute < 6'd60), "time out of range")
	`ASSERT_CLK(a_hold_steps, clk, arst_n, (adv && op_s1 == phcs_pkg::OP_EDGE && armed_q && is_hold |=> adjust_select_q == 2'($past(adjust_select_q) + 2'd1)), "hold did not step selector")

endmodule

`default_nettype wire

// ===== tb/sv/tb_press_hold_clock_setter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_press_hold_clock_setter_core
// Self-checking bench for the press/hold clock setter core.
// ----------------------------------------------------------------------------
// Streams tick and button-edge words into the core with bursty input timing
// and a patterned output stall. A scoreboard class tracks the arm/count/
// selector/display state and predicts each result word, which is compared
// field by field in order. Threshold is swept through reset, zero, small and
// top values; threshold edges are hit with tick runs of threshold and +1.
// ----------------------------------------------------------------------------

module tb_press_hold_clock_setter_core;

	// scoreboard: own copy of the setter state, queue of predicted words
	class clock_setter_scoreboard;
		logic [phcs_pkg::CountW-1:0] hold_threshold;
		logic                        armed;
		logic [phcs_pkg::CountW-1:0] hold_count;
		logic [1:0]                  adjust_select;
		logic                        display_mode;
		phcs_pkg::result_t           setter_out_q[$];
		int unsigned                 mismatches;
		int unsigned                 unexpected;
		int unsigned                 words_checked;
		int unsigned                 presses;
		int unsigned                 holds;
		int unsigned                 time_sets;

		function new();
			hold_threshold = phcs_pkg::HoldThresholdReset;
			armed          = 1'b0;
			hold_count     = '0;
			adjust_select  = phcs_pkg::SEL_MODE;
			display_mode   = 1'b0;
			mismatches     = 0;
			unexpected     = 0;
			words_checked  = 0;
			presses        = 0;
			holds          = 0;
			time_sets      = 0;
		endfunction

		function void set_threshold(logic [phcs_pkg::CountW-1:0] value);
			hold_threshold = value;
		endfunction

		function logic is_armed();
			return armed;
		endfunction

		function int unsigned pending_count();
			return setter_out_q.size();
		endfunction

		// next state and result word for one accepted input word
		function phcs_pkg::result_t predict_setter_out(logic op_i,
				logic [phcs_pkg::HourW-1:0] hour_i, logic [phcs_pkg::MinuteW-1:0] minute_i);
			phcs_pkg::result_t r;
			logic [5:0]        hour;
			logic [6:0]        minute;
			r      = '0;
			hour   = {1'b0, hour_i};
			minute = {1'b0, minute_i};
			if (op_i == phcs_pkg::OP_TICK) begin
				if (armed && hold_count != phcs_pkg::CountMax)
					hold_count = hold_count + 1'b1;
			end else if (!armed) begin
				armed      = 1'b1;
				hold_count = '0;
			end else begin
				armed = 1'b0;
				if (hold_count > hold_threshold) begin
					r.event_kind  = phcs_pkg::EV_HOLD;
					adjust_select = adjust_select + 2'd1;
				end else begin
					r.event_kind = phcs_pkg::EV_PRESS;
					if (adjust_select == phcs_pkg::SEL_MODE) begin
						display_mode = ~display_mode;
					end else begin
						case (adjust_select)
							phcs_pkg::SEL_HOUR: hour   = hour + 6'd1;
							phcs_pkg::SEL_TEN:  minute = minute + phcs_pkg::TenMinutes;
							default:            minute = minute + 7'd1;
						endcase
						// minute carry, then 24h wrap (also folds bad hours)
						if (minute >= phcs_pkg::MinutesPerHour) begin
							minute = minute - phcs_pkg::MinutesPerHour;
							hour   = hour + 6'd1;
						end
						hour         = hour % phcs_pkg::HoursPerDay;
						r.set_time   = 1'b1;
						r.new_hour   = hour[phcs_pkg::HourW-1:0];
						r.new_minute = minute[phcs_pkg::MinuteW-1:0];
					end
				end
				hold_count = '0;
			end
			r.display_mode  = display_mode;
			r.adjust_select = adjust_select;
			return r;
		endfunction

		function void accept_input(logic op_i, logic [phcs_pkg::HourW-1:0] hour_i,
				logic [phcs_pkg::MinuteW-1:0] minute_i);
			setter_out_q.push_back(predict_setter_out(op_i, hour_i, minute_i));
		endfunction

		function void check_output(phcs_pkg::result_t got);
			phcs_pkg::result_t want;
			if (setter_out_q.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= 10)
					$display("unexpected result word: kind %0d set %0d %0d:%0d",
						got.event_kind, got.set_time, got.new_hour, got.new_minute);
				return;
			end
			want = setter_out_q.pop_front();
			words_checked++;
			if (want.event_kind == phcs_pkg::EV_PRESS) presses++;
			if (want.event_kind == phcs_pkg::EV_HOLD) holds++;
			if (want.set_time) time_sets++;
			if (got.event_kind != want.event_kind || got.set_time != want.set_time ||
					got.new_hour != want.new_hour || got.new_minute != want.new_minute ||
					got.display_mode != want.display_mode ||
					got.adjust_select != want.adjust_select) begin
				mismatches++;
				if (mismatches + unexpected <= 10) begin
					$write("mismatch word %0d: kind %0d/%0d set %0d/%0d hour %0d/%0d ",
						words_checked, want.event_kind, got.event_kind,
						want.set_time, got.set_time, want.new_hour, got.new_hour);
					$display("minute %0d/%0d mode %0d/%0d sel %0d/%0d (exp/act)",
						want.new_minute, got.new_minute, want.display_mode,
						got.display_mode, want.adjust_select, got.adjust_select);
				end
			end
		endfunction
	endclass

	localparam int unsigned CycleLimit   = 3_000_000;
	localparam int unsigned RandomPhases = 5;
	localparam int unsigned PhaseWords   = 390;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_we;
	logic [phcs_pkg::CountW-1:0]  cfg_data;
	logic                         in_valid;
	logic                         in_stall;
	logic                         op;
	logic [phcs_pkg::HourW-1:0]   clock_hour;
	logic [phcs_pkg::MinuteW-1:0] clock_minute;
	logic                         out_valid;
	logic                         out_stall;
	logic [1:0]                   event_kind;
	logic                         set_time;
	logic [phcs_pkg::HourW-1:0]   new_hour;
	logic [phcs_pkg::MinuteW-1:0] new_minute;
	logic                         display_mode_out;
	logic [1:0]                   adjust_select_out;

	clock_setter_scoreboard sb;

	int unsigned cycles;
	int unsigned burst_left;
	int unsigned words_sent;
	int unsigned live_words;      // edge words, and tick words sent while armed
	int unsigned threshold_writes;

	press_hold_clock_setter_core u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.op                (op),
		.clock_hour        (clock_hour),
		.clock_minute      (clock_minute),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.event_kind        (event_kind),
		.set_time          (set_time),
		.new_hour          (new_hour),
		.new_minute        (new_minute),
		.display_mode_out  (display_mode_out),
		.adjust_select_out (adjust_select_out)
	);

	always #6 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycles, sb.pending_count());
			$display("FAILURE");
			$finish;
		end
	end

	// result monitor: one check per accepted output word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_output(phcs_pkg::result_t'({event_kind, set_time, new_hour,
				new_minute, display_mode_out, adjust_select_out}));
	end

	// receiver stall: stretches of no stall, light random, heavy random, periodic
	initial begin
		int unsigned mode;
		int unsigned span;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 300);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 2) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= (cycles % 3 == 0);
				endcase
			end
		end
	end

	// mostly legal clock values, sometimes anything the field holds
	function automatic logic [phcs_pkg::HourW-1:0] rand_hour();
		if ($urandom_range(0, 4) == 0)
			return phcs_pkg::HourW'($urandom_range(0, 31));
		return phcs_pkg::HourW'($urandom_range(0, 23));
	endfunction

	function automatic logic [phcs_pkg::MinuteW-1:0] rand_minute();
		if ($urandom_range(0, 4) == 0)
			return phcs_pkg::MinuteW'($urandom_range(0, 63));
		return phcs_pkg::MinuteW'($urandom_range(0, 59));
	endfunction

	// one input word; the sender runs in bursts with idle gaps between them
	task automatic send_word(input logic op_i, input logic [phcs_pkg::HourW-1:0] hour_i,
			input logic [phcs_pkg::MinuteW-1:0] minute_i);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
				: $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		burst_left--;
		if (op_i == phcs_pkg::OP_EDGE || sb.is_armed())
			live_words++;
		in_valid     <= 1'b1;
		op           <= op_i;
		clock_hour   <= hour_i;
		clock_minute <= minute_i;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.accept_input(op_i, hour_i, minute_i);
		words_sent++;
	endtask

	// arm edge, tick run, disarm edge carrying the clock time to adjust
	task automatic button_action(input int unsigned ticks,
			input logic [phcs_pkg::HourW-1:0] hour_i,
			input logic [phcs_pkg::MinuteW-1:0] minute_i);
		send_word(phcs_pkg::OP_EDGE, rand_hour(), rand_minute());
		repeat (ticks) send_word(phcs_pkg::OP_TICK, rand_hour(), rand_minute());
		send_word(phcs_pkg::OP_EDGE, hour_i, minute_i);
	endtask

	// threshold only changes with the core drained
	task automatic write_hold_threshold(input logic [phcs_pkg::CountW-1:0] value);
		in_valid <= 1'b0;
		while (sb.pending_count() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_threshold(value);
		threshold_writes++;
	endtask

	// mostly well-formed press/hold actions around the threshold, some noise
	task automatic random_phase(input int unsigned thr, input int unsigned target);
		int unsigned start;
		int unsigned n;
		int unsigned k;
		start = live_words;
		while (live_words - start < target) begin
			if ($urandom_range(0, 99) < 85) begin
				if (sb.is_armed())
					send_word(phcs_pkg::OP_EDGE, rand_hour(), rand_minute());
				if (thr > 40)
					n = $urandom_range(0, 30);
				else if ($urandom_range(0, 4) == 0)
					n = thr + $urandom_range(0, 1);
				else
					n = $urandom_range(0, thr + thr / 2 + 3);
				button_action(n, rand_hour(), rand_minute());
			end else begin
				k = $urandom_range(1, 6);
				repeat (k) send_word(logic'($urandom_range(0, 1)),
					phcs_pkg::HourW'($urandom_range(0, 31)),
					phcs_pkg::MinuteW'($urandom_range(0, 63)));
			end
		end
	endtask

	initial begin
		int unsigned thr_list[RandomPhases];
		sb               = new();
		cycles           = 0;
		burst_left       = 0;
		words_sent       = 0;
		live_words       = 0;
		threshold_writes = 0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_data         = '0;
		in_valid         = 1'b0;
		op               = phcs_pkg::OP_TICK;
		clock_hour       = '0;
		clock_minute     = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset threshold: ticks while idle leave the count alone, short
		// actions are presses that toggle the display
		send_word(phcs_pkg::OP_TICK, 5'd0, 6'd0);
		send_word(phcs_pkg::OP_TICK, 5'd31, 6'd63);
		button_action(0, 5'd0, 6'd0);
		button_action(25, 5'd12, 6'd30);

		// zero threshold: no ticks is a press, one tick a hold; walk every
		// selector with carries, 24-hour wrap and out-of-range clock values
		write_hold_threshold(16'd0);
		button_action(0, 5'd23, 6'd59);
		button_action(0, 5'd10, 6'd63);
		button_action(0, 5'd31, 6'd62);
		button_action(1, 5'd0, 6'd0);
		button_action(0, 5'd5, 6'd55);
		button_action(0, 5'd23, 6'd50);
		button_action(1, 5'd0, 6'd0);
		button_action(0, 5'd23, 6'd0);
		button_action(0, 5'd31, 6'd63);
		button_action(0, 5'd24, 6'd59);
		button_action(1, 5'd0, 6'd0);
		button_action(0, 5'd0, 6'd0);

		thr_list[0] = 0;
		thr_list[1] = $urandom_range(1, 12);
		thr_list[2] = 65535;
		thr_list[3] = $urandom_range(13, 40);
		thr_list[4] = 3;
		foreach (thr_list[i]) begin
			write_hold_threshold(phcs_pkg::CountW'(thr_list[i]));
			random_phase(thr_list[i], PhaseWords);
		end

		// drain
		in_valid <= 1'b0;
		while (sb.pending_count() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d words sent over %0d threshold settings, %0d results checked",
			words_sent, threshold_writes + 1, sb.words_checked);
		$display("%0d presses, %0d holds, %0d time updates, %0d mismatches, %0d extra",
			sb.presses, sb.holds, sb.time_sets, sb.mismatches, sb.unexpected);
		if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending_count() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/phcs_pkg.sv
design/press_hold_clock_setter_core.sv
tb/sv/tb_press_hold_clock_setter_core.sv
